>>> design/pmi_pkg.sv
// Shared types, codes and saturating arithmetic for the particle motion integrator.
package pmi_pkg;

    localparam int WORD_W    = 32;
    localparam int IMASS_W   = 31;
    localparam int CFG_IDX_W = 3;
    localparam int FRAC_BITS = 16;
    localparam int LANES     = 3;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [LANES-1:0][WORD_W-1:0] vec3_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [2:0] {
        CMD_ADD_FORCE   = 3'd0,
        CMD_ADD_IMPULSE = 3'd1,
        CMD_STEP        = 3'd2,
        CMD_SET_POS     = 3'd3,
        CMD_SET_VEL     = 3'd4,
        CMD_SET_LIFE    = 3'd5
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_MASS = 3'd0,
        REG_ACCEL_X  = 3'd1,
        REG_ACCEL_Y  = 3'd2,
        REG_ACCEL_Z  = 3'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_APPLY,
        PH_MUL_FORCE,
        PH_MUL_IMPULSE,
        PH_MUL_DV,
        PH_HALF,
        PH_MUL_POS,
        PH_ADD_POS
    } phase_t;

    typedef struct packed {
        phase_t phase;
        cmd_t   cmd;
    } lane_ctrl_t;

    function automatic word_t sat_wide(input logic signed [2*WORD_W-1:0] v);
        word_t r;
        if (v[2*WORD_W-1:WORD_W-1] == {(WORD_W+1){1'b0}} ||
            v[2*WORD_W-1:WORD_W-1] == {(WORD_W+1){1'b1}})
            r = v[WORD_W-1:0];
        else
            r = v[2*WORD_W-1] ? WORD_MIN : WORD_MAX;
        return r;
    endfunction

    function automatic word_t sat_add(input word_t a, input word_t b);
        logic [WORD_W:0] s;
        word_t r;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1])
            r = s[WORD_W] ? WORD_MIN : WORD_MAX;
        else
            r = s[WORD_W-1:0];
        return r;
    endfunction

    function automatic word_t sat_sub(input word_t a, input word_t b);
        logic [WORD_W:0] s;
        word_t r;
        s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1])
            r = s[WORD_W] ? WORD_MIN : WORD_MAX;
        else
            r = s[WORD_W-1:0];
        return r;
    endfunction

endpackage

>>> design/particle_motion_integrator_core.sv
// Top level of the particle motion integrator: command control, config, life and lanes.
//
//   channel | signals                                               | direction
//   --------+-------------------------------------------------------+------------
//   in      | in_valid, in_ready, command, vec_*, scalar            | into core
//   out     | out_valid, out_ready, pos_*, vel_*, life_left, alive  | out of core
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data             | into core
//
// Step commands run phases MUL_FORCE, MUL_IMPULSE, MUL_DV, HALF, MUL_POS, ADD_POS and
// hold the core until the result register loads; the per-lane multiplier runs the force,
// impulse, velocity and position products plus their saturating sums in sequence.
// Other commands pass one apply phase before the load. Reset clears all particle state
// and sets inverse mass to one. A stalled result holds in the output register; the next
// transaction is accepted meanwhile and waits at completion until the register frees.
module particle_motion_integrator_core #(
    parameter int FRAC_BITS = pmi_pkg::FRAC_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [2:0]                     command,
    input  pmi_pkg::word_t                 vec_x,
    input  pmi_pkg::word_t                 vec_y,
    input  pmi_pkg::word_t                 vec_z,
    input  pmi_pkg::word_t                 scalar,
    output logic                           out_valid,
    input  logic                           out_ready,
    output pmi_pkg::word_t                 pos_x,
    output pmi_pkg::word_t                 pos_y,
    output pmi_pkg::word_t                 pos_z,
    output pmi_pkg::word_t                 vel_x,
    output pmi_pkg::word_t                 vel_y,
    output pmi_pkg::word_t                 vel_z,
    output pmi_pkg::word_t                 life_left,
    output logic                           alive,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pmi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pmi_pkg::WORD_W-1:0]     cfg_data
);

    localparam int IMASS_W = pmi_pkg::IMASS_W;
    localparam int LANES   = pmi_pkg::LANES;
    localparam logic [IMASS_W-1:0] IMASS_ONE = {{(IMASS_W-1){1'b0}}, 1'b1} << FRAC_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WORK,
        ST_DONE
    } state_t;

    state_t                 state_reg, state_next;
    pmi_pkg::phase_t        phase_reg, phase_next;
    pmi_pkg::cmd_t          cmd_reg, cmd_next;
    pmi_pkg::vec3_t         vec_reg, vec_next;
    pmi_pkg::word_t         scalar_reg, scalar_next;
    pmi_pkg::word_t         life_reg, life_next;
    logic [IMASS_W-1:0]     imass_reg, imass_next;
    pmi_pkg::vec3_t         accel_reg, accel_next;

    pmi_pkg::lane_ctrl_t    lane_ctrl;
    pmi_pkg::vec3_t         lane_pos;
    pmi_pkg::vec3_t         lane_vel;
    logic                   merge_free;
    logic                   merge_load;
    logic                   in_fire;
    logic                   cfg_fire;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign merge_load = (state_reg == ST_DONE) && merge_free;

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        cmd_next    = cmd_reg;
        vec_next    = vec_reg;
        scalar_next = scalar_reg;
        life_next   = life_reg;
        imass_next  = imass_reg;
        accel_next  = accel_reg;

        if (cfg_fire)
        begin
            case (cfg_index)
                pmi_pkg::REG_INV_MASS: imass_next   = cfg_data[IMASS_W-1:0];
                pmi_pkg::REG_ACCEL_X:  accel_next[0] = cfg_data;
                pmi_pkg::REG_ACCEL_Y:  accel_next[1] = cfg_data;
                pmi_pkg::REG_ACCEL_Z:  accel_next[2] = cfg_data;
                default:               imass_next   = imass_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next    = pmi_pkg::cmd_t'(command);
                    vec_next    = {vec_z, vec_y, vec_x};
                    scalar_next = scalar;
                    state_next  = ST_WORK;
                    phase_next  = (pmi_pkg::cmd_t'(command) == pmi_pkg::CMD_STEP) ?
                                  pmi_pkg::PH_MUL_FORCE : pmi_pkg::PH_APPLY;
                end
            end
            ST_WORK:
            begin
                case (phase_reg)
                    pmi_pkg::PH_APPLY:
                    begin
                        if (cmd_reg == pmi_pkg::CMD_SET_LIFE)
                            life_next = scalar_reg;
                        phase_next = pmi_pkg::PH_IDLE;
                        state_next = ST_DONE;
                    end
                    pmi_pkg::PH_MUL_FORCE:   phase_next = pmi_pkg::PH_MUL_IMPULSE;
                    pmi_pkg::PH_MUL_IMPULSE: phase_next = pmi_pkg::PH_MUL_DV;
                    pmi_pkg::PH_MUL_DV:      phase_next = pmi_pkg::PH_HALF;
                    pmi_pkg::PH_HALF:        phase_next = pmi_pkg::PH_MUL_POS;
                    pmi_pkg::PH_MUL_POS:     phase_next = pmi_pkg::PH_ADD_POS;
                    pmi_pkg::PH_ADD_POS:
                    begin
                        if (life_reg != '0 && life_reg != pmi_pkg::WORD_MAX)
                            life_next = pmi_pkg::sat_sub(life_reg, scalar_reg);
                        phase_next = pmi_pkg::PH_IDLE;
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        phase_next = pmi_pkg::PH_IDLE;
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_DONE:
            begin
                if (merge_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
                phase_next = pmi_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= pmi_pkg::PH_IDLE;
            cmd_reg    <= pmi_pkg::CMD_ADD_FORCE;
            vec_reg    <= '0;
            scalar_reg <= '0;
            life_reg   <= '0;
            imass_reg  <= IMASS_ONE;
            accel_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            cmd_reg    <= cmd_next;
            vec_reg    <= vec_next;
            scalar_reg <= scalar_next;
            life_reg   <= life_next;
            imass_reg  <= imass_next;
            accel_reg  <= accel_next;
        end
    end

    assign lane_ctrl.phase = phase_reg;
    assign lane_ctrl.cmd   = cmd_reg;

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        pmi_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (lane_ctrl),
            .vec   (vec_reg[g]),
            .dt    (scalar_reg),
            .imass (imass_reg),
            .accel (accel_reg[g]),
            .pos   (lane_pos[g]),
            .vel   (lane_vel[g])
        );
    end

    pmi_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (merge_load),
        .pos       (lane_pos),
        .vel       (lane_vel),
        .life      (life_reg),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .free      (merge_free),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .vel_z     (vel_z),
        .life_left (life_left),
        .alive     (alive)
    );

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("input accepted while a transaction is still in flight");

    a_step_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == pmi_pkg::PH_ADD_POS) |=> (state_reg == ST_DONE))
        else $error("step sequence did not complete after the position add");

    a_alive_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (alive == !life_left[pmi_pkg::WORD_W-1]))
        else $error("alive flag disagrees with remaining life sign");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        merge_load |=> out_valid)
        else $error("result load did not raise out_valid");

endmodule

>>> design/pmi_lane.sv
// One axis lane: holds position, velocity and accumulators, steps them with a shared multiplier.
module pmi_lane #(
    parameter int FRAC_BITS = pmi_pkg::FRAC_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pmi_pkg::lane_ctrl_t          ctrl,
    input  pmi_pkg::word_t               vec,
    input  pmi_pkg::word_t               dt,
    input  logic [pmi_pkg::IMASS_W-1:0]  imass,
    input  pmi_pkg::word_t               accel,
    output pmi_pkg::word_t               pos,
    output pmi_pkg::word_t               vel
);

    localparam int W = pmi_pkg::WORD_W;

    pmi_pkg::word_t pos_reg, pos_next;
    pmi_pkg::word_t vel_reg, vel_next;
    pmi_pkg::word_t frc_reg, frc_next;
    pmi_pkg::word_t imp_reg, imp_next;
    pmi_pkg::word_t prod_reg, prod_next;
    pmi_pkg::word_t tmp_reg, tmp_next;
    pmi_pkg::word_t v_reg, v_next;

    pmi_pkg::word_t        mul_a;
    pmi_pkg::word_t        mul_b;
    logic [2*W-1:0]        prod_raw;
    logic signed [2*W-1:0] prod_shift;
    pmi_pkg::word_t        prod_sat;
    pmi_pkg::word_t        imass_word;

    assign imass_word = {1'b0, imass};

    always_comb
    begin
        case (ctrl.phase)
            pmi_pkg::PH_MUL_FORCE:
            begin
                mul_a = frc_reg;
                mul_b = imass_word;
            end
            pmi_pkg::PH_MUL_IMPULSE:
            begin
                mul_a = imp_reg;
                mul_b = imass_word;
            end
            pmi_pkg::PH_MUL_DV:
            begin
                mul_a = tmp_reg;
                mul_b = dt;
            end
            default:
            begin
                mul_a = tmp_reg;
                mul_b = dt;
            end
        endcase
    end

    assign prod_raw   = (2*W)'(mul_a * mul_b);
    assign prod_shift = $signed(prod_raw) >>> FRAC_BITS;
    assign prod_sat   = pmi_pkg::sat_wide(prod_shift);

    always_comb
    begin
        pos_next  = pos_reg;
        vel_next  = vel_reg;
        frc_next  = frc_reg;
        imp_next  = imp_reg;
        prod_next = prod_reg;
        tmp_next  = tmp_reg;
        v_next    = v_reg;
        case (ctrl.phase)
            pmi_pkg::PH_APPLY:
            begin
                case (ctrl.cmd)
                    pmi_pkg::CMD_ADD_FORCE:   frc_next = pmi_pkg::sat_add(frc_reg, vec);
                    pmi_pkg::CMD_ADD_IMPULSE: imp_next = pmi_pkg::sat_add(imp_reg, vec);
                    pmi_pkg::CMD_SET_POS:     pos_next = vec;
                    pmi_pkg::CMD_SET_VEL:     vel_next = vec;
                    default:                  pos_next = pos_reg;
                endcase
            end
            pmi_pkg::PH_MUL_FORCE:
            begin
                prod_next = prod_sat;
            end
            pmi_pkg::PH_MUL_IMPULSE:
            begin
                prod_next = prod_sat;
                tmp_next  = pmi_pkg::sat_add(accel, prod_reg);
            end
            pmi_pkg::PH_MUL_DV:
            begin
                prod_next = prod_sat;
                v_next    = pmi_pkg::sat_add(vel_reg, prod_reg);
            end
            pmi_pkg::PH_HALF:
            begin
                tmp_next = pmi_pkg::sat_add(v_reg, prod_reg >>> 1);
                vel_next = pmi_pkg::sat_add(v_reg, prod_reg);
                frc_next = '0;
                imp_next = '0;
            end
            pmi_pkg::PH_MUL_POS:
            begin
                prod_next = prod_sat;
            end
            pmi_pkg::PH_ADD_POS:
            begin
                pos_next = pmi_pkg::sat_add(pos_reg, prod_reg);
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            vel_reg <= '0;
            frc_reg <= '0;
            imp_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            vel_reg <= vel_next;
            frc_reg <= frc_next;
            imp_reg <= imp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        tmp_reg  <= tmp_next;
        v_reg    <= v_next;
    end

    assign pos = pos_reg;
    assign vel = vel_reg;

endmodule

>>> design/pmi_merge.sv
// Merge stage: gathers the lane states and life into the registered result transaction.
module pmi_merge (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  pmi_pkg::vec3_t  pos,
    input  pmi_pkg::vec3_t  vel,
    input  pmi_pkg::word_t  life,
    input  logic            out_ready,
    output logic            out_valid,
    output logic            free,
    output pmi_pkg::word_t  pos_x,
    output pmi_pkg::word_t  pos_y,
    output pmi_pkg::word_t  pos_z,
    output pmi_pkg::word_t  vel_x,
    output pmi_pkg::word_t  vel_y,
    output pmi_pkg::word_t  vel_z,
    output pmi_pkg::word_t  life_left,
    output logic            alive
);

    logic           out_valid_reg, out_valid_next;
    pmi_pkg::vec3_t pos_reg, pos_next;
    pmi_pkg::vec3_t vel_reg, vel_next;
    pmi_pkg::word_t life_reg, life_next;

    assign free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        pos_next       = pos_reg;
        vel_next       = vel_reg;
        life_next      = life_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            pos_next       = pos;
            vel_next       = vel;
            life_next      = life;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        vel_reg  <= vel_next;
        life_reg <= life_next;
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_reg[0];
    assign pos_y     = pos_reg[1];
    assign pos_z     = pos_reg[2];
    assign vel_x     = vel_reg[0];
    assign vel_y     = vel_reg[1];
    assign vel_z     = vel_reg[2];
    assign life_left = life_reg;
    assign alive     = !life_reg[pmi_pkg::WORD_W-1];

endmodule
